// ===== sv/assert_macros.svh =====
// assertion macros used by the executor rtl file
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== sv/tme_pkg.sv =====
// constants for the tape machine instruction executor
// store depths, derived widths, command, status and instruction codes; no dependencies
`timescale 1ns / 1ps
package tme_pkg;
  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 4096;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int TAPE_AW    = $clog2(TAPE_DEPTH);
  localparam int PC_W       = PROG_AW + 1;
  localparam int TS_W       = TAPE_AW + 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_HALTED    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_UNMATCHED = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd0;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
endpackage

// ===== sv/tape_machine_instruction_executor.sv =====
// tape machine executor: program store and tape memories, sequencer, output register
// depends on tme_pkg and assert_macros.svh
// load and step items both read the program and tape, then execute once the output register is free
// a bracket scan walks the program byte by byte in S_FWD or S_BWD, then reports from S_DONE
// a new item is taken only in S_IDLE, after the last one has produced its result
// rst_n is synchronous; after reset a pass clears every tape cell, the item input stalls meanwhile
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tape_machine_instruction_executor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [tme_pkg::PROG_AW-1:0] in_load_address,
  input  logic [7:0]                 in_program_byte,
  input  logic                       in_last_byte,
  input  logic [7:0]                 in_input_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_output_valid,
  output logic [7:0]                 out_output_byte,
  output logic                       out_input_taken,
  output logic [2:0]                 out_status,
  output logic [tme_pkg::PC_W-1:0]   out_next_pc,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tme_pkg::TS_W-1:0]   cfg_tape_size
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_FWD, S_BWD, S_DONE} state_t;

  localparam int PC_W    = tme_pkg::PC_W;
  localparam int PROG_AW = tme_pkg::PROG_AW;
  localparam int TAPE_AW = tme_pkg::TAPE_AW;
  localparam int TS_W    = tme_pkg::TS_W;

  state_t               state_r, state_nxt;
  logic [TAPE_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [TS_W-1:0]      tape_size_r, tape_size_nxt;
  logic [PC_W-1:0]      len_r, len_nxt;
  logic [PC_W-1:0]      pc_r, pc_nxt;
  logic [TAPE_AW-1:0]   dp_r, dp_nxt;
  logic [2:0]           fault_r, fault_nxt;
  logic                 cmd_r, cmd_nxt;
  logic [PROG_AW-1:0]   addr_r, addr_nxt;
  logic [7:0]           pbyte_r, pbyte_nxt;
  logic                 last_r, last_nxt;
  logic [7:0]           ibyte_r, ibyte_nxt;
  logic [PC_W-1:0]      j_r, j_nxt;
  logic [PC_W-1:0]      depth_r, depth_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ov_r, out_ov_nxt;
  logic [7:0]           out_ob_r, out_ob_nxt;
  logic                 out_it_r, out_it_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [PC_W-1:0]      out_pc_r, out_pc_nxt;

  // program store and tape
  logic [7:0]           prog_mem [tme_pkg::PROG_DEPTH];
  logic [7:0]           tape_mem [tme_pkg::TAPE_DEPTH];
  logic [7:0]           prog_q_r, tape_q_r;
  logic                 prog_we, prog_re, tape_we, tape_re;
  logic [PROG_AW-1:0]   prog_waddr, prog_raddr;
  logic [7:0]           prog_wdata, tape_wdata;
  logic [TAPE_AW-1:0]   tape_waddr, tape_raddr;

  logic                 in_accept;
  logic                 out_free;
  logic [TS_W-1:0]      eff_size;
  logic [PC_W-1:0]      pc_inc;
  logic [PC_W-1:0]      depth_step;
  logic                 emit;
  logic                 ov, it;
  logic [7:0]           ob;

  function automatic logic [2:0] status_of(input logic [2:0] f, input logic [PC_W-1:0] pc,
                                           input logic [PC_W-1:0] len);
    logic [2:0] s;
    if (f != tme_pkg::ST_NONE) s = f;
    else if (pc >= len) s = tme_pkg::ST_HALTED;
    else s = tme_pkg::ST_RUNNING;
    return s;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign pc_inc    = pc_r + PC_W'(1);

  always_comb begin
    if (tape_size_r == '0) eff_size = TS_W'(1);
    else if (tape_size_r > TS_W'(tme_pkg::TAPE_DEPTH)) eff_size = TS_W'(tme_pkg::TAPE_DEPTH);
    else eff_size = tape_size_r;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    tape_size_nxt = cfg_valid ? cfg_tape_size : tape_size_r;
    len_nxt       = len_r;
    pc_nxt        = pc_r;
    dp_nxt        = dp_r;
    fault_nxt     = fault_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    pbyte_nxt     = pbyte_r;
    last_nxt      = last_r;
    ibyte_nxt     = ibyte_r;
    j_nxt         = j_r;
    depth_nxt     = depth_r;
    depth_step    = depth_r;
    emit          = 1'b0;
    ov            = 1'b0;
    ob            = 8'd0;
    it            = 1'b0;
    prog_we       = 1'b0;
    prog_waddr    = addr_r;
    prog_wdata    = pbyte_r;
    prog_re       = 1'b0;
    prog_raddr    = pc_r[PROG_AW-1:0];
    tape_we       = 1'b0;
    tape_waddr    = dp_r;
    tape_wdata    = 8'd0;
    tape_re       = 1'b0;
    tape_raddr    = dp_r;

    unique case (state_r)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + TAPE_AW'(1);
        if (clr_cnt_r == TAPE_AW'(tme_pkg::TAPE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt   = in_command;
          addr_nxt  = in_load_address;
          pbyte_nxt = in_program_byte;
          last_nxt  = in_last_byte;
          ibyte_nxt = in_input_byte;
          prog_re   = 1'b1;
          tape_re   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // nothing commits until the output register can take the result
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (cmd_r == tme_pkg::CMD_LOAD) begin
            prog_we = 1'b1;
            if (last_r) begin
              len_nxt   = PC_W'(addr_r) + PC_W'(1);
              pc_nxt    = '0;
              dp_nxt    = '0;
              fault_nxt = tme_pkg::ST_NONE;
            end
          end else if (fault_r == tme_pkg::ST_NONE && pc_r < len_r) begin
            pc_nxt = pc_inc;
            unique case (prog_q_r)
              tme_pkg::CH_RIGHT: begin
                if (TS_W'(dp_r) + TS_W'(1) >= eff_size) begin
                  fault_nxt = tme_pkg::ST_OVERFLOW;
                  pc_nxt    = pc_r;
                end else dp_nxt = dp_r + TAPE_AW'(1);
              end
              tme_pkg::CH_LEFT: begin
                if (dp_r == '0) begin
                  fault_nxt = tme_pkg::ST_UNDERFLOW;
                  pc_nxt    = pc_r;
                end else dp_nxt = dp_r - TAPE_AW'(1);
              end
              tme_pkg::CH_INC: begin
                tape_we    = 1'b1;
                tape_wdata = tape_q_r + 8'd1;
              end
              tme_pkg::CH_DEC: begin
                tape_we    = 1'b1;
                tape_wdata = tape_q_r - 8'd1;
              end
              tme_pkg::CH_OUT: begin
                ov = 1'b1;
                ob = tape_q_r;
              end
              tme_pkg::CH_IN: begin
                it         = 1'b1;
                tape_we    = 1'b1;
                tape_wdata = ibyte_r;
              end
              tme_pkg::CH_OPEN: begin
                if (tape_q_r == 8'd0) begin
                  pc_nxt = pc_r;
                  if (pc_inc >= len_r) fault_nxt = tme_pkg::ST_UNMATCHED;
                  else begin
                    emit       = 1'b0;
                    prog_re    = 1'b1;
                    prog_raddr = pc_inc[PROG_AW-1:0];
                    j_nxt      = pc_inc;
                    depth_nxt  = PC_W'(1);
                    state_nxt  = S_FWD;
                  end
                end
              end
              tme_pkg::CH_CLOSE: begin
                pc_nxt = pc_r;
                if (pc_r == '0) fault_nxt = tme_pkg::ST_UNMATCHED;
                else begin
                  emit       = 1'b0;
                  prog_re    = 1'b1;
                  prog_raddr = PROG_AW'(pc_r - PC_W'(1));
                  j_nxt      = pc_r - PC_W'(1);
                  depth_nxt  = PC_W'(1);
                  state_nxt  = S_BWD;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_FWD: begin
        if (prog_q_r == tme_pkg::CH_OPEN) depth_step = depth_r + PC_W'(1);
        else if (prog_q_r == tme_pkg::CH_CLOSE) depth_step = depth_r - PC_W'(1);
        depth_nxt = depth_step;
        if (depth_step == '0) begin
          pc_nxt    = j_r + PC_W'(1);
          state_nxt = S_DONE;
        end else if (j_r + PC_W'(1) >= len_r) begin
          fault_nxt = tme_pkg::ST_UNMATCHED;
          state_nxt = S_DONE;
        end else begin
          j_nxt      = j_r + PC_W'(1);
          prog_re    = 1'b1;
          prog_raddr = PROG_AW'(j_r + PC_W'(1));
        end
      end
      S_BWD: begin
        if (prog_q_r == tme_pkg::CH_CLOSE) depth_step = depth_r + PC_W'(1);
        else if (prog_q_r == tme_pkg::CH_OPEN) depth_step = depth_r - PC_W'(1);
        depth_nxt = depth_step;
        if (depth_step == '0) begin
          pc_nxt    = j_r;
          state_nxt = S_DONE;
        end else if (j_r == '0) begin
          fault_nxt = tme_pkg::ST_UNMATCHED;
          state_nxt = S_DONE;
        end else begin
          j_nxt      = j_r - PC_W'(1);
          prog_re    = 1'b1;
          prog_raddr = PROG_AW'(j_r - PC_W'(1));
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_ov_nxt     = ov;
      out_ob_nxt     = ob;
      out_it_nxt     = it;
      out_status_nxt = status_of(fault_nxt, pc_nxt, len_nxt);
      out_pc_nxt     = pc_nxt;
    end else begin
      out_valid_nxt  = out_valid_r && out_stall;
      out_ov_nxt     = out_ov_r;
      out_ob_nxt     = out_ob_r;
      out_it_nxt     = out_it_r;
      out_status_nxt = out_status_r;
      out_pc_nxt     = out_pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      tape_size_r <= TS_W'(tme_pkg::TAPE_DEPTH);
      len_r       <= '0;
      pc_r        <= '0;
      dp_r        <= '0;
      fault_r     <= tme_pkg::ST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      tape_size_r <= tape_size_nxt;
      len_r       <= len_nxt;
      pc_r        <= pc_nxt;
      dp_r        <= dp_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    pbyte_r      <= pbyte_nxt;
    last_r       <= last_nxt;
    ibyte_r      <= ibyte_nxt;
    j_r          <= j_nxt;
    depth_r      <= depth_nxt;
    out_ov_r     <= out_ov_nxt;
    out_ob_r     <= out_ob_nxt;
    out_it_r     <= out_it_nxt;
    out_status_r <= out_status_nxt;
    out_pc_r     <= out_pc_nxt;
  end

  always_ff @(posedge clk) begin
    if (prog_we) prog_mem[prog_waddr] <= prog_wdata;
    if (prog_re) prog_q_r <= prog_mem[prog_raddr];
  end

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    if (tape_re) tape_q_r <= tape_mem[tape_raddr];
  end

  assign out_valid        = out_valid_r;
  assign out_output_valid = out_ov_r;
  assign out_output_byte  = out_ob_r;
  assign out_input_taken  = out_it_r;
  assign out_status       = out_status_r;
  assign out_next_pc      = out_pc_r;

  `ASSERT_CHK(a_clear_no_result, clk, rst_n, (state_r == S_CLEAR) |-> !out_valid_r, "result during tape clear")
  `ASSERT_CHK(a_result_pc_current, clk, rst_n, out_valid_r |-> (out_pc_r == pc_r), "pending result pc differs from state")
  `ASSERT_CHK(a_fwd_in_program, clk, rst_n, (state_r == S_FWD) |-> (j_r < len_r), "forward scan past program end")
  `ASSERT_NEVER(a_out_and_in, clk, rst_n, out_valid_r && out_ov_r && out_it_r, "output and input in one result")

endmodule
